// ----- sv/mwc_random_range_generator_defines.svh -----
// Assertion macros shared by the range generator RTL.
`ifndef MWC_RANDOM_RANGE_GENERATOR_DEFINES_SVH
`define MWC_RANDOM_RANGE_GENERATOR_DEFINES_SVH

// Clocked property on clk_i, disabled while rst_ni is low.
`define MWC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle implies a condition in the next cycle.
`define MWC_ASSERT_NEXT(lbl, pre, post, msg) \
  `MWC_ASSERT_CLK(lbl, (pre) |=> (post), msg)

`endif

// ----- sv/mwcrrg_pkg.sv -----
// Package with types and constants of the multiply-with-carry range generator.
`timescale 1ns / 1ps
`default_nettype none

package mwcrrg_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned HalfWidth = 16;
  localparam int unsigned CfgIndexWidth = 8;
  localparam int unsigned StepCountWidth = $clog2(WordWidth);

  // Generator constants.
  localparam logic [HalfWidth-1:0] ZMult = 16'd36969;
  localparam logic [HalfWidth-1:0] WMult = 16'd18000;
  localparam logic [WordWidth-1:0] WInit = 32'd521288629;
  localparam logic [WordWidth-1:0] ZInit = 32'd362436069;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] RegSeedW = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegSeedZ = 8'd1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIVIDE,
    ST_FINISH
  } seq_state_e;

  // Configuration write as seen by the generator state.
  typedef struct packed {
    logic                     en;
    logic [CfgIndexWidth-1:0] index;
    logic [WordWidth-1:0]     data;
  } cfg_wr_t;

  // Status of the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

// ----- sv/mwcrrg_state.sv -----
// Generator state: the two multiply-with-carry halves and their seed loads.
`timescale 1ns / 1ps
`default_nettype none

module mwcrrg_state
  import mwcrrg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cfg_wr_t              cfg_wr_i,
  input  wire logic                 draw_i,
  output logic     [WordWidth-1:0]  raw_next_o
);

  logic [WordWidth-1:0] half_w_q, half_w_d;
  logic [WordWidth-1:0] half_z_q, half_z_d;
  logic [WordWidth-1:0] z_step, w_step;

  // One step of each half: a 16x16 product plus the carry half.
  assign z_step = ({{HalfWidth{1'b0}}, ZMult} * {{HalfWidth{1'b0}}, half_z_q[HalfWidth-1:0]})
                + {{HalfWidth{1'b0}}, half_z_q[WordWidth-1:HalfWidth]};
  assign w_step = ({{HalfWidth{1'b0}}, WMult} * {{HalfWidth{1'b0}}, half_w_q[HalfWidth-1:0]})
                + {{HalfWidth{1'b0}}, half_w_q[WordWidth-1:HalfWidth]};

  // Word of the draw that is being made this cycle.
  assign raw_next_o = {z_step[HalfWidth-1:0], {HalfWidth{1'b0}}} + w_step;

  // A nonzero seed write reloads its half; a draw advances both halves only when no configuration write is present.
  always_comb begin
    half_w_d = half_w_q;
    half_z_d = half_z_q;
    if (cfg_wr_i.en) begin
      if (cfg_wr_i.index == RegSeedW && cfg_wr_i.data != '0) begin
        half_w_d = cfg_wr_i.data;
      end
      if (cfg_wr_i.index == RegSeedZ && cfg_wr_i.data != '0) begin
        half_z_d = cfg_wr_i.data;
      end
    end else if (draw_i) begin
      half_w_d = w_step;
      half_z_d = z_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_w_q <= WInit;
      half_z_q <= ZInit;
    end else begin
      half_w_q <= half_w_d;
      half_z_q <= half_z_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/mwcrrg_divider.sv -----
// Restoring divider that gives the remainder, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module mwcrrg_divider
  import mwcrrg_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [WordWidth-1:0] dividend_i,
  input  wire logic [WordWidth-1:0] divisor_i,
  output div_status_t               status_o,
  output logic      [WordWidth-1:0] remainder_o
);

  localparam logic [StepCountWidth-1:0] LastStep = StepCountWidth'(WordWidth - 1);

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [StepCountWidth-1:0] cnt_q, cnt_d;
  logic [WordWidth-1:0]      rem_q, rem_d;
  logic [WordWidth-1:0]      dvd_q, dvd_d;
  logic [WordWidth-1:0]      dvs_q, dvs_d;
  logic [WordWidth:0]        trial;
  logic [WordWidth:0]        diff;

  // Bring down the next dividend bit and try to subtract the divisor.
  assign trial = {rem_q, dvd_q[WordWidth-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so it fits in one word.
      rem_d = diff[WordWidth] ? trial[WordWidth-1:0] : diff[WordWidth-1:0];
      dvd_d = {dvd_q[WordWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign remainder_o   = rem_q;

endmodule

`default_nettype wire

// ----- sv/mwc_random_range_generator.sv -----
// Multiply-with-carry random generator that maps each draw into a requested range.
//
// Input channel (in_valid_i / in_ready_o) takes one word with range_low_i and
// range_high_i. Output channel (out_valid_o / out_ready_i) returns one word per
// input word: ranged_value_o, raw_value_o, coin_o and drew_o.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes seed_w (index 0) or
// seed_z (index 1); a nonzero seed reloads that half of the generator. Other
// indexes are ignored. Write configuration only while the block is idle.
// A non-empty range passes from acceptance through a draw, the restoring
// divider that reduces the draw modulo the span, the addition of the lower
// bound and the load of the output register before out_valid_o rises. An
// empty range (low >= high) makes no draw. One word is in work at a time;
// in_ready_o is high only while the sequencer is idle, so a new word is taken
// only after the last one has been loaded into the output register.
// The output register holds a finished word while the receiver stalls, and
// the next word may be accepted and worked on meanwhile; its result waits
// in the sequencer until the output register is free.
// Reset returns both halves to their default seeds and empties the block.
`timescale 1ns / 1ps
`default_nettype none

`include "mwc_random_range_generator_defines.svh"

module mwc_random_range_generator
  import mwcrrg_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [WordWidth-1:0]     cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [WordWidth-1:0]     range_low_i,
  input  wire logic [WordWidth-1:0]     range_high_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic      [WordWidth-1:0]     ranged_value_o,
  output logic      [WordWidth-1:0]     raw_value_o,
  output logic                          coin_o,
  output logic                          drew_o
);

  seq_state_e           state_q, state_d;
  cfg_wr_t              cfg_wr;
  div_status_t          div_stat;
  logic                 draw;
  logic                 div_start;
  logic                 in_accept;
  logic [WordWidth-1:0] raw_next;
  logic [WordWidth-1:0] remainder;

  // Work registers of the word in flight.
  logic [WordWidth-1:0] lo_q, lo_d;
  logic [WordWidth-1:0] span_q, span_d;
  logic [WordWidth-1:0] ranged_q, ranged_d;
  logic [WordWidth-1:0] raw_q, raw_d;
  logic                 drew_q, drew_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [WordWidth-1:0] out_ranged_q, out_ranged_d;
  logic [WordWidth-1:0] out_raw_q, out_raw_d;
  logic                 out_drew_q, out_drew_d;

  // Configuration writes are always taken.
  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.en    = cfg_valid_i & cfg_ready_o;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  mwcrrg_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .draw_i     (draw),
    .raw_next_o (raw_next)
  );

  mwcrrg_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (raw_next),
    .divisor_i   (span_q),
    .status_o    (div_stat),
    .remainder_o (remainder)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i & in_ready_o;

  // Sequencer: next state, control strobes and register updates.
  always_comb begin
    state_d      = state_q;
    draw         = 1'b0;
    div_start    = 1'b0;
    lo_d         = lo_q;
    span_d       = span_q;
    ranged_d     = ranged_q;
    raw_d        = raw_q;
    drew_d       = drew_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_ranged_d = out_ranged_q;
    out_raw_d    = out_raw_q;
    out_drew_d   = out_drew_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          lo_d   = range_low_i;
          span_d = range_high_i - range_low_i;
          if (range_low_i >= range_high_i) begin
            // Empty range: the lower bound comes back and no draw is made.
            ranged_d = range_low_i;
            raw_d    = '0;
            drew_d   = 1'b0;
            state_d  = ST_FINISH;
          end else begin
            state_d = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        draw      = 1'b1;
        div_start = 1'b1;
        raw_d     = raw_next;
        drew_d    = 1'b1;
        state_d   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done) begin
          ranged_d = lo_q + remainder;
          state_d  = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_ranged_d = ranged_q;
          out_raw_d    = raw_q;
          out_drew_d   = drew_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q         <= lo_d;
    span_q       <= span_d;
    ranged_q     <= ranged_d;
    raw_q        <= raw_d;
    drew_q       <= drew_d;
    out_ranged_q <= out_ranged_d;
    out_raw_q    <= out_raw_d;
    out_drew_q   <= out_drew_d;
  end

  assign out_valid_o    = out_valid_q;
  assign ranged_value_o = out_ranged_q;
  assign raw_value_o    = out_raw_q;
  assign coin_o         = out_raw_q[0];
  assign drew_o         = out_drew_q;

  // Checks on the sequencer and the result word.
  `MWC_ASSERT_CLK(a_nodraw_zero, (out_valid_o && !drew_o) |-> (raw_value_o == '0 && !coin_o), "word without a draw carries a nonzero raw value")
  `MWC_ASSERT_CLK(a_done_in_divide, div_stat.done |-> (state_q == ST_DIVIDE), "divider finished outside the divide state")
  `MWC_ASSERT_CLK(a_busy_in_divide, div_stat.busy |-> (state_q == ST_DIVIDE), "divider busy outside the divide state")
  `MWC_ASSERT_NEXT(a_draw_follows, (in_accept && range_low_i < range_high_i), (state_q == ST_DRAW), "non-empty range did not start a draw")
  `MWC_ASSERT_NEXT(a_empty_skips, (in_accept && range_low_i >= range_high_i), (state_q == ST_FINISH), "empty range did not go straight to finish")

endmodule

`default_nettype wire
